// ===== src/tmr_pkg.sv =====
`timescale 1ns / 1ps

package tmr_pkg;

   // Request kinds carried by the input channel.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // Register map.
   localparam logic [3:0] REG_CTRL    = 4'd0;
   localparam logic [3:0] REG_STATUS  = 4'd1;
   localparam logic [3:0] REG_EVENT   = 4'd2;
   localparam logic [3:0] REG_CMPMODE = 4'd3;
   localparam logic [3:0] REG_OUTEN   = 4'd4;
   localparam logic [3:0] REG_MAINOUT = 4'd5;
   localparam logic [3:0] REG_COUNT   = 4'd6;
   localparam logic [3:0] REG_PRESC   = 4'd7;
   localparam logic [3:0] REG_RELOAD  = 4'd8;
   localparam logic [3:0] REG_COMPARE = 4'd9;

   // Compare channel modes (low three bits of the mode register).
   localparam logic [2:0] MODE_FORCE_LOW  = 3'b100;
   localparam logic [2:0] MODE_FORCE_HIGH = 3'b101;
   localparam logic [2:0] MODE_PWM1       = 3'b110;
   localparam logic [2:0] MODE_PWM2       = 3'b111;

   localparam int MODE_PRELOAD_BIT = 3;
   localparam int MOE_BIT          = 15;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  index;
      logic [15:0] data;
   } item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        pwm_out;
      logic        update_flag;
   } result_type;

endpackage

// ===== src/tmr_channels.sv =====
`timescale 1ns / 1ps

interface tmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  reg_index;
   logic [15:0] write_data;

   modport source (output valid, output req_type, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input req_type, input reg_index, input write_data,
                   output ready);
endinterface

interface tmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        pwm_out;
   logic        update_flag;

   modport source (output valid, output read_data, output pwm_out, output update_flag,
                   input ready);
   modport sink   (input valid, input read_data, input pwm_out, input update_flag,
                   output ready);
endinterface

// ===== src/timer_with_pwm_compare.sv =====
`timescale 1ns / 1ps

// General-purpose up-counting timer with one PWM compare channel.
// The request channel carries one item per transfer: a clock tick, a register
// read or a register write (type, register index, write data). Every request
// produces exactly one response transfer carrying the read data (zero unless
// the item was a read), the PWM pin level and the update flag as they stand
// after that item.
// A request is held in an input register, from which the core applies it to
// the timer state; the response is then held in an output register. The
// response reaches the output register only after the request has passed
// through the input register, and can be taken once it is there.
// Throughput is one item per cycle while the receiver takes the responses;
// the core works each item on the state left by the previous item.
// When the receiver stalls, the response stays in the output register and the
// input register keeps one further request; the request channel drops ready
// only once both are occupied and the response is still not taken.
// Synchronous reset empties both registers and returns the timer to its reset
// state: counter stopped at zero, reload all ones, outputs disabled.
module timer_with_pwm_compare
   import tmr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   tmr_req_if.sink   req_chan,
   tmr_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type core_result;
   logic       advance;
   logic       req_fire;
   logic       core_fire;

   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign core_fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   tmr_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (core_fire),
      .item   (item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= {req_chan.req_type, req_chan.reg_index, req_chan.write_data};
      end
      if (core_fire) begin
         result_ff <= core_result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = result_ff.read_data;
   assign rsp_chan.pwm_out     = result_ff.pwm_out;
   assign rsp_chan.update_flag = result_ff.update_flag;

   // An accepted request is always held in the input register next cycle.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted request lost from the input register");

   // A held request moves on only into a free or draining output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(result_ff)))
      else $error("pending response overwritten");

   // A forced update event must show a set update flag in its response.
   a_forced_update: assert property (@(posedge clock) disable iff (reset)
      (core_fire && item_ff.kind == REQ_WRITE && item_ff.index == REG_EVENT
       && item_ff.data[0]) |=> (out_valid_ff && result_ff.update_flag))
      else $error("forced update did not set the update flag");

   // Without any request held, no new response may appear.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !out_valid_ff) |=> !out_valid_ff)
      else $error("response produced without a request");

endmodule

// ===== src/tmr_core.sv =====
`timescale 1ns / 1ps

module tmr_core
   import tmr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

   logic [COUNTER_WIDTH-1:0] counter_ff, counter_in;
   logic [15:0]              presc_count_ff, presc_count_in;
   logic [15:0]              presc_preload_ff, presc_preload_in;
   logic [15:0]              presc_active_ff, presc_active_in;
   logic [COUNTER_WIDTH-1:0] reload_ff, reload_in;
   logic [COUNTER_WIDTH-1:0] cmp_preload_ff, cmp_preload_in;
   logic [COUNTER_WIDTH-1:0] cmp_active_ff, cmp_active_in;
   logic                     enable_ff, enable_in;
   logic [3:0]               mode_ff, mode_in;
   logic [1:0]               outen_ff, outen_in;
   logic                     flag_ff, flag_in;
   logic                     ref_ff, ref_in;

   logic [COUNTER_WIDTH-1:0] data_cnt;
   logic [15:0]              read_value;
   logic                     update;
   logic                     below;

   assign data_cnt = COUNTER_WIDTH'(item.data);

   always_comb begin
      counter_in       = counter_ff;
      presc_count_in   = presc_count_ff;
      presc_preload_in = presc_preload_ff;
      presc_active_in  = presc_active_ff;
      reload_in        = reload_ff;
      cmp_preload_in   = cmp_preload_ff;
      cmp_active_in    = cmp_active_ff;
      enable_in        = enable_ff;
      mode_in          = mode_ff;
      outen_in         = outen_ff;
      flag_in          = flag_ff;
      update           = 1'b0;
      read_value       = 16'd0;

      if (item.kind == REQ_TICK) begin
         if (enable_ff) begin
            if (presc_count_ff >= presc_active_ff) begin
               presc_count_in = 16'd0;
               if (counter_ff >= reload_ff) begin
                  counter_in = '0;
                  update     = 1'b1;
               end else begin
                  counter_in = counter_ff + CNT_ONE;
               end
            end else begin
               presc_count_in = presc_count_ff + 16'd1;
            end
         end
      end else if (item.kind == REQ_READ) begin
         unique case (item.index)
            REG_CTRL:    read_value = {15'd0, enable_ff};
            REG_STATUS:  read_value = {15'd0, flag_ff};
            REG_CMPMODE: read_value = {12'd0, mode_ff};
            REG_OUTEN:   read_value = {15'd0, outen_ff[0]};
            REG_MAINOUT: read_value = {outen_ff[1], 15'd0};
            REG_COUNT:   read_value = 16'(counter_ff);
            REG_PRESC:   read_value = presc_preload_ff;
            REG_RELOAD:  read_value = 16'(reload_ff);
            REG_COMPARE: read_value = 16'(cmp_preload_ff);
            default:     read_value = 16'd0;
         endcase
      end else if (item.kind == REQ_WRITE) begin
         unique case (item.index)
            REG_CTRL:    enable_in = item.data[0];
            REG_STATUS:  flag_in = flag_ff & item.data[0];
            REG_EVENT: begin
               if (item.data[0]) begin
                  counter_in     = '0;
                  presc_count_in = 16'd0;
                  update         = 1'b1;
               end
            end
            REG_CMPMODE: mode_in = item.data[3:0];
            REG_OUTEN:   outen_in[0] = item.data[0];
            REG_MAINOUT: outen_in[1] = item.data[MOE_BIT];
            REG_COUNT:   counter_in = data_cnt;
            REG_PRESC:   presc_preload_in = item.data;
            REG_RELOAD:  reload_in = data_cnt;
            REG_COMPARE: begin
               cmp_preload_in = data_cnt;
               if (!mode_ff[MODE_PRELOAD_BIT]) begin
                  cmp_active_in = data_cnt;
               end
            end
            default: ;
         endcase
      end

      // An update event loads the shadow copies from the preload registers and sets the update flag.
      if (update) begin
         presc_active_in = presc_preload_ff;
         cmp_active_in   = cmp_preload_ff;
         flag_in         = 1'b1;
      end

      // The reference level follows the state as it stands after this item.
      below  = counter_in < cmp_active_in;
      ref_in = ref_ff;
      unique case (mode_in[2:0])
         MODE_PWM1:       ref_in = below;
         MODE_PWM2:       ref_in = ~below;
         MODE_FORCE_LOW:  ref_in = 1'b0;
         MODE_FORCE_HIGH: ref_in = 1'b1;
         default:         ref_in = ref_ff;
      endcase
   end

   assign result.read_data   = read_value;
   assign result.pwm_out     = (outen_in == 2'b11) & ref_in;
   assign result.update_flag = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff       <= '0;
         presc_count_ff   <= 16'd0;
         presc_preload_ff <= 16'd0;
         presc_active_ff  <= 16'd0;
         reload_ff        <= '1;
         cmp_preload_ff   <= '0;
         cmp_active_ff    <= '0;
         enable_ff        <= 1'b0;
         mode_ff          <= 4'd0;
         outen_ff         <= 2'b00;
         flag_ff          <= 1'b0;
         ref_ff           <= 1'b0;
      end else if (fire) begin
         counter_ff       <= counter_in;
         presc_count_ff   <= presc_count_in;
         presc_preload_ff <= presc_preload_in;
         presc_active_ff  <= presc_active_in;
         reload_ff        <= reload_in;
         cmp_preload_ff   <= cmp_preload_in;
         cmp_active_ff    <= cmp_active_in;
         enable_ff        <= enable_in;
         mode_ff          <= mode_in;
         outen_ff         <= outen_in;
         flag_ff          <= flag_in;
         ref_ff           <= ref_in;
      end
   end

endmodule

// ===== tb/sv/tb_timer_with_pwm_compare.sv =====
`timescale 1ns / 1ps

module tb_timer_with_pwm_compare;
   import tmr_pkg::*;

   localparam logic [1:0] REQ_NOP          = 2'd3;
   localparam int         CYCLE_LIMIT      = 400000;
   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         TAIL_CYCLES      = 20;
   localparam int         PHASE_ITEMS      = 360;

   // Predicts the response of every request from its own copy of the timer state,
   // keeps the responses still owed by the block and compares what comes back.
   class timer_scoreboard;
      logic [15:0] count_q;
      logic [15:0] psc_count;
      logic [15:0] psc_preload;
      logic [15:0] psc_active;
      logic [15:0] reload_q;
      logic [15:0] cmp_preload;
      logic [15:0] cmp_active;
      logic        enable;
      logic [3:0]  mode;
      logic        ch_en;
      logic        main_en;
      logic        uif;
      logic        ref_lvl;
      result_type  pending_responses[$];
      int          errors;
      int          updates;
      int          checked;
      int          kind_count[4];

      function new();
         reset_state();
         errors  = 0;
         checked = 0;
         kind_count = '{0, 0, 0, 0};
      endfunction

      function void reset_state();
         count_q     = '0;
         psc_count   = '0;
         psc_preload = '0;
         psc_active  = '0;
         reload_q    = '1;
         cmp_preload = '0;
         cmp_active  = '0;
         enable      = 1'b0;
         mode        = '0;
         ch_en       = 1'b0;
         main_en     = 1'b0;
         uif         = 1'b0;
         ref_lvl     = 1'b0;
         updates     = 0;
         pending_responses.delete();
      endfunction

      function void load_shadows();
         psc_active = psc_preload;
         cmp_active = cmp_preload;
         uif        = 1'b1;
         updates++;
      endfunction

      function result_type predict_response(item_type it);
         result_type r;
         logic       below;
         r = '0;
         case (it.kind)
            REQ_TICK: begin
               if (enable) begin
                  if (psc_count >= psc_active) begin
                     psc_count = '0;
                     if (count_q >= reload_q) begin
                        count_q = '0;
                        load_shadows();
                     end else begin
                        count_q++;
                     end
                  end else begin
                     psc_count++;
                  end
               end
            end
            REQ_READ: begin
               case (it.index)
                  REG_CTRL:    r.read_data[0] = enable;
                  REG_STATUS:  r.read_data[0] = uif;
                  REG_CMPMODE: r.read_data[3:0] = mode;
                  REG_OUTEN:   r.read_data[0] = ch_en;
                  REG_MAINOUT: r.read_data[MOE_BIT] = main_en;
                  REG_COUNT:   r.read_data = count_q;
                  REG_PRESC:   r.read_data = psc_preload;
                  REG_RELOAD:  r.read_data = reload_q;
                  REG_COMPARE: r.read_data = cmp_preload;
                  default:     r.read_data = '0;
               endcase
            end
            REQ_WRITE: begin
               case (it.index)
                  REG_CTRL:    enable = it.data[0];
                  REG_STATUS:  uif = uif & it.data[0];
                  REG_EVENT: begin
                     if (it.data[0]) begin
                        count_q   = '0;
                        psc_count = '0;
                        load_shadows();
                     end
                  end
                  REG_CMPMODE: mode = it.data[3:0];
                  REG_OUTEN:   ch_en = it.data[0];
                  REG_MAINOUT: main_en = it.data[MOE_BIT];
                  REG_COUNT:   count_q = it.data;
                  REG_PRESC:   psc_preload = it.data;
                  REG_RELOAD:  reload_q = it.data;
                  REG_COMPARE: begin
                     cmp_preload = it.data;
                     if (!mode[MODE_PRELOAD_BIT]) cmp_active = it.data;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase

         // Frozen mode and the unused codes leave the reference level where it was.
         below = (count_q < cmp_active);
         case (mode[2:0])
            MODE_PWM1:       ref_lvl = below;
            MODE_PWM2:       ref_lvl = !below;
            MODE_FORCE_LOW:  ref_lvl = 1'b0;
            MODE_FORCE_HIGH: ref_lvl = 1'b1;
            default: ;
         endcase
         r.pwm_out     = ch_en & main_en & ref_lvl;
         r.update_flag = uif;
         return r;
      endfunction

      function void note_request(item_type it);
         kind_count[it.kind]++;
         pending_responses.push_back(predict_response(it));
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("ERROR: response %0d: %s got 0x%04h, expected 0x%04h",
                  checked, what, got, want);
         errors++;
      endtask

      task check_response(result_type got);
         result_type want;
         if (pending_responses.size() == 0) begin
            report("response with no request outstanding", got.read_data, '0);
         end else begin
            want = pending_responses.pop_front();
            if (got.read_data !== want.read_data)
               report("read_data", got.read_data, want.read_data);
            if (got.pwm_out !== want.pwm_out)
               report("pwm_out", 16'(got.pwm_out), 16'(want.pwm_out));
            if (got.update_flag !== want.update_flag)
               report("update_flag", 16'(got.update_flag), 16'(want.update_flag));
         end
         checked++;
      endtask

      function int pending();
         return pending_responses.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic long_hold;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count;

   timer_scoreboard sb;

   tmr_req_if req_chan();
   tmr_rsp_if rsp_chan();

   timer_with_pwm_compare u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timer_with_pwm_compare test failed");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off counted here on request.
   initial begin : receiver
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (long_hold && !hold_taken) begin
            hold_left  = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
         if (!long_hold) hold_taken = 1'b0;
      end
   end

   // Every request transfer is noted before any response transfer of the same edge is checked.
   always @(posedge clock) begin : monitor
      item_type   seen_req;
      result_type seen_rsp;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req = '{kind: req_chan.req_type, index: req_chan.reg_index,
                         data: req_chan.write_data};
            sb.note_request(seen_req);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp = '{read_data: rsp_chan.read_data, pwm_out: rsp_chan.pwm_out,
                         update_flag: rsp_chan.update_flag};
            sb.check_response(seen_rsp);
         end
      end
   end

   task send_request(logic [1:0] kind, logic [3:0] index, logic [15:0] data);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.reg_index  <= index;
      req_chan.write_data <= data;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Mostly ticks against small reload, prescale and compare values so that the counter
   // wraps often; the rest is reads, register writes, unmapped indexes and no-ops.
   function automatic item_type random_request();
      item_type it;
      int       pick;
      it.kind  = REQ_TICK;
      it.index = 4'($urandom_range(0, 15));
      it.data  = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick >= 55 && pick < 70) begin
         it.kind = REQ_READ;
         if ($urandom_range(0, 9) != 0) it.index = 4'($urandom_range(0, 9));
      end else if (pick >= 70 && pick < 97) begin
         it.kind = REQ_WRITE;
         if ($urandom_range(0, 9) != 0) it.index = 4'($urandom_range(0, 9));
         case (it.index)
            REG_CTRL:    it.data[0] = ($urandom_range(0, 9) < 8);
            REG_CMPMODE: begin
               if ($urandom_range(0, 9) < 7)
                  it.data[2:0] = $urandom_range(0, 1) ? MODE_PWM1 : MODE_PWM2;
            end
            REG_OUTEN:   it.data[0] = ($urandom_range(0, 9) < 8);
            REG_MAINOUT: it.data[MOE_BIT] = ($urandom_range(0, 9) < 8);
            REG_PRESC: begin
               if ($urandom_range(0, 19) != 0) it.data = 16'($urandom_range(0, 3));
            end
            REG_COUNT, REG_RELOAD, REG_COMPARE: begin
               if ($urandom_range(0, 9) != 0) it.data = 16'($urandom_range(0, 12));
            end
            default: ;
         endcase
      end else if (pick >= 97) begin
         it.kind = REQ_NOP;
      end
      return it;
   endfunction

   task run_random(int count, int sender_idle, int receiver_stall);
      item_type it;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (count) begin
         it = random_request();
         send_request(it.kind, it.index, it.data);
      end
   endtask

   initial begin
      sb = new();
      reset               = 1'b1;
      long_hold           = 1'b0;
      idle_pct            = 0;
      stall_pct           = 0;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_TICK;
      req_chan.reg_index  = REG_CTRL;
      req_chan.write_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: reset values, each register, wraps and the forced update.
      send_request(REQ_READ,  REG_RELOAD,  16'h0000);
      send_request(REQ_TICK,  REG_CTRL,    16'h0000);
      send_request(REQ_WRITE, REG_CMPMODE, 16'(MODE_PWM1));
      send_request(REQ_WRITE, REG_OUTEN,   16'h0001);
      send_request(REQ_WRITE, REG_MAINOUT, 16'h0001 << MOE_BIT);
      send_request(REQ_WRITE, REG_COMPARE, 16'h0002);
      send_request(REQ_WRITE, REG_CTRL,    16'h0001);
      repeat (3) send_request(REQ_TICK, REG_CTRL, 16'h0000);
      send_request(REQ_WRITE, REG_COUNT,   16'hFFFF);
      send_request(REQ_WRITE, REG_RELOAD,  16'h0005);
      send_request(REQ_TICK,  REG_CTRL,    16'h0000);
      send_request(REQ_WRITE, REG_STATUS,  16'hFFFF);
      send_request(REQ_WRITE, REG_STATUS,  16'hFFFE);
      send_request(REQ_WRITE, REG_CMPMODE, {12'h000, 1'b1, MODE_PWM2});
      send_request(REQ_WRITE, REG_COMPARE, 16'hFFFF);
      send_request(REQ_WRITE, REG_PRESC,   16'h0003);
      send_request(REQ_WRITE, REG_EVENT,   16'h0001);
      send_request(REQ_WRITE, REG_RELOAD,  16'h0000);
      send_request(REQ_TICK,  REG_CTRL,    16'h0000);
      send_request(REQ_WRITE, REG_CMPMODE, 16'(MODE_FORCE_HIGH));
      send_request(REQ_WRITE, REG_CMPMODE, 16'(MODE_FORCE_LOW));
      send_request(REQ_NOP,   4'hF,        16'hFFFF);
      send_request(REQ_WRITE, 4'hC,        16'hFFFF);
      send_request(REQ_READ,  4'hD,        16'h0000);

      run_random(PHASE_ITEMS, 0, 0);
      run_random(PHASE_ITEMS, 79, 0);
      run_random(PHASE_ITEMS, 0, 79);
      run_random(PHASE_ITEMS, 16, 16);

      // The receiver holds off for a long stretch while requests keep coming, so the
      // block fills up and refuses further transfers until the hold ends.
      long_hold <= 1'b1;
      run_random(120, 0, 0);
      long_hold <= 1'b0;

      // The sender pauses until every owed response has arrived, then carries on.
      wait_for_drain();
      run_random(250, 16, 16);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report("responses never delivered", 16'(sb.pending()), '0);

      $display("Run covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d no-ops.",
               sb.kind_count[REQ_TICK] + sb.kind_count[REQ_READ] + sb.kind_count[REQ_WRITE]
               + sb.kind_count[REQ_NOP], sb.kind_count[REQ_TICK], sb.kind_count[REQ_READ],
               sb.kind_count[REQ_WRITE], sb.kind_count[REQ_NOP]);
      $display("%0d update events seen over free-running, sparse, stalled and held-off traffic.",
               sb.updates);
      if (sb.errors == 0) begin
         $display("timer_with_pwm_compare test passed");
      end else begin
         $display("timer_with_pwm_compare test failed");
      end
      $finish;
   end

endmodule
